// ----- rtl/efc_pkg.sv -----
// Shared types and constants of the Ethernet frame classifier.
package efc_pkg;

    localparam int unsigned MacWidth    = 48;
    localparam int unsigned CountWidth  = 7;
    localparam int unsigned OffsetWidth = 7;

    localparam logic [CountWidth-1:0] CountMax     = 7'd127;
    localparam logic [CountWidth-1:0] PosTypeHigh  = 7'd12;
    localparam logic [CountWidth-1:0] PosTypeLow   = 7'd13;
    localparam logic [CountWidth-1:0] EthHdrLen    = 7'd14;
    localparam logic [CountWidth-1:0] PosProtocol  = 7'd23;
    localparam logic [CountWidth-1:0] MacBytes     = 7'd6;
    localparam logic [OffsetWidth-1:0] UdpHdrLen   = 7'd8;

    localparam logic [15:0] TypeIpv4 = 16'h0800;
    localparam logic [15:0] TypeArp  = 16'h0806;

    localparam logic [7:0] ProtoIcmp = 8'd1;
    localparam logic [7:0] ProtoTcp  = 8'd6;
    localparam logic [7:0] ProtoUdp  = 8'd17;

    localparam logic [15:0] PortDhcpServer = 16'd67;
    localparam logic [15:0] PortDhcpClient = 16'd68;

    typedef enum logic [2:0] {
        CLASS_ICMP       = 3'd0,
        CLASS_DHCP_RESP  = 3'd1,
        CLASS_TCP        = 3'd2,
        CLASS_ARP        = 3'd3,
        CLASS_IPV4_OTHER = 3'd4,
        CLASS_UDP_OTHER  = 3'd5,
        CLASS_NOT_OURS   = 3'd6,
        CLASS_OTHER_TYPE = 3'd7
    } frame_class_t;

    typedef struct packed {
        frame_class_t            frame_class;
        logic [OffsetWidth-1:0]  payload_offset;
    } result_t;

endpackage

// ----- rtl/efc_byte_if.sv -----
// Byte request channel: one frame byte and its last-byte flag.
interface efc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ----- rtl/efc_result_if.sv -----
// Result request channel: frame class and handler header offset.
interface efc_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] frame_class;
    logic [6:0] payload_offset;

    modport source (output valid, output frame_class, output payload_offset, input ready);
    modport sink   (input valid, input frame_class, input payload_offset, output ready);
endinterface

// ----- rtl/efc_parser.sv -----
// Per-frame header field capture and classification on the final byte.
module efc_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [efc_pkg::MacWidth-1:0]      cfg_wr_data,
    input  logic                              accept,
    input  logic [7:0]                        frame_byte,
    input  logic                              last_byte,
    output logic                              push,
    output efc_pkg::result_t                  result
);
    import efc_pkg::*;

    logic [MacWidth-1:0]   own_mac_reg;
    logic [CountWidth-1:0] byte_count_reg,   byte_count_next;
    logic                  mac_matches_reg,  mac_matches_next;
    logic [15:0]           ether_kind_reg,   ether_kind_next;
    logic [3:0]            header_words_reg, header_words_next;
    logic [7:0]            ip_protocol_reg,  ip_protocol_next;
    logic [15:0]           source_port_reg,  source_port_next;
    logic [15:0]           dest_port_reg,    dest_port_next;

    logic [CountWidth-1:0] pos;
    logic [2:0]            mac_sel;
    logic [7:0]            mac_byte;
    logic                  mac_hit;
    logic                  tail_miss;
    logic                  mac_final;
    logic [CountWidth-1:0] base;
    logic [CountWidth-1:0] rel;
    logic                  in_window;
    frame_class_t          cls;
    logic [OffsetWidth-1:0] off;

    assign pos     = byte_count_reg;
    assign mac_sel = 3'd5 - pos[2:0];
    assign mac_byte = own_mac_reg[{mac_sel, 3'b000} +: 8];

    always_comb
    begin
        mac_hit = mac_matches_reg;
        if (pos < MacBytes && frame_byte != mac_byte)
        begin
            mac_hit = 1'b0;
        end

        ether_kind_next = ether_kind_reg;
        if (pos == PosTypeHigh)
        begin
            ether_kind_next[15:8] = frame_byte;
        end
        if (pos == PosTypeLow)
        begin
            ether_kind_next[7:0] = frame_byte;
        end

        header_words_next = (pos == EthHdrLen) ? frame_byte[3:0] : header_words_reg;
        ip_protocol_next  = (pos == PosProtocol) ? frame_byte : ip_protocol_reg;

        // The port window follows the header length, including this byte's update.
        base      = EthHdrLen + {1'b0, header_words_next, 2'b00};
        rel       = pos - base;
        in_window = (pos >= base) && (rel[CountWidth-1:2] == '0);

        source_port_next = source_port_reg;
        dest_port_next   = dest_port_reg;
        if (in_window)
        begin
            case (rel[1:0])
                2'd0:    source_port_next[15:8] = frame_byte;
                2'd1:    source_port_next[7:0]  = frame_byte;
                2'd2:    dest_port_next[15:8]   = frame_byte;
                default: dest_port_next[7:0]    = frame_byte;
            endcase
        end

        // Destination bytes that a short frame never delivered compare as zero.
        tail_miss = 1'b0;
        for (int k = 1; k < 6; k++)
        begin
            if (CountWidth'(k) > pos && own_mac_reg[8*(5-k) +: 8] != 8'd0)
            begin
                tail_miss = 1'b1;
            end
        end
        mac_final = mac_hit && !tail_miss;
    end

    always_comb
    begin
        off = '0;
        if (ether_kind_next == TypeIpv4)
        begin
            if (!mac_final)
            begin
                cls = CLASS_NOT_OURS;
            end
            else if (ip_protocol_next == ProtoIcmp)
            begin
                cls = CLASS_ICMP;
                off = base;
            end
            else if (ip_protocol_next == ProtoUdp)
            begin
                if (source_port_next == PortDhcpServer && dest_port_next == PortDhcpClient)
                begin
                    cls = CLASS_DHCP_RESP;
                    off = base + UdpHdrLen;
                end
                else
                begin
                    cls = CLASS_UDP_OTHER;
                end
            end
            else if (ip_protocol_next == ProtoTcp)
            begin
                cls = CLASS_TCP;
                off = base;
            end
            else
            begin
                cls = CLASS_IPV4_OTHER;
            end
        end
        else if (ether_kind_next == TypeArp)
        begin
            cls = CLASS_ARP;
            off = EthHdrLen;
        end
        else
        begin
            cls = CLASS_OTHER_TYPE;
        end
    end

    always_comb
    begin
        byte_count_next  = (pos < CountMax) ? pos + 7'd1 : CountMax;
        mac_matches_next = mac_hit;
    end

    assign push                  = accept && last_byte;
    assign result.frame_class    = cls;
    assign result.payload_offset = off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            own_mac_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            mac_matches_reg  <= 1'b1;
            ether_kind_reg   <= '0;
            header_words_reg <= '0;
            ip_protocol_reg  <= '0;
            source_port_reg  <= '0;
            dest_port_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                byte_count_reg   <= '0;
                mac_matches_reg  <= 1'b1;
                ether_kind_reg   <= '0;
                header_words_reg <= '0;
                ip_protocol_reg  <= '0;
                source_port_reg  <= '0;
                dest_port_reg    <= '0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                mac_matches_reg  <= mac_matches_next;
                ether_kind_reg   <= ether_kind_next;
                header_words_reg <= header_words_next;
                ip_protocol_reg  <= ip_protocol_next;
                source_port_reg  <= source_port_next;
                dest_port_reg    <= dest_port_next;
            end
        end
    end

    a_mismatch_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        !mac_matches_reg |-> byte_count_reg != '0)
        else $error("MAC mismatch recorded before any byte of the frame");

    a_ihl_after_its_byte: assert property (@(posedge clk) disable iff (!rst_n)
        header_words_reg != '0 |-> byte_count_reg > EthHdrLen)
        else $error("header length captured before its byte position");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> byte_count_reg == '0 && mac_matches_reg)
        else $error("per-frame state not cleared after the final byte");

endmodule

// ----- rtl/efc_out_buf.sv -----
// Result register with a skid stage so input keeps flowing while a result waits.
module efc_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  efc_pkg::result_t  push_data,
    output logic              in_ready,
    output logic              out_valid,
    output efc_pkg::result_t  out_data,
    input  logic              out_ready
);
    import efc_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    pop;
    logic    load_main_new;
    logic    load_main_skid;
    logic    load_skid;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb
    begin
        load_main_skid  = skid_valid_reg && pop;
        load_main_new   = push && (!main_valid_reg || pop);
        load_skid       = push && main_valid_reg && !pop;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (load_main_skid)
        begin
            skid_valid_next = 1'b0;
        end
        else if (load_main_new)
        begin
            main_valid_next = 1'b1;
        end
        else if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_main_skid)
        begin
            main_data_reg <= skid_data_reg;
        end
        else if (load_main_new)
        begin
            main_data_reg <= push_data;
        end
        if (load_skid)
        begin
            skid_data_reg <= push_data;
        end
    end

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while the result register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("result request pushed into a full buffer");

    a_stalled_push_skids: assert property (@(posedge clk) disable iff (!rst_n)
        push && main_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("stalled result was not kept in the skid stage");

endmodule

// ----- rtl/ethernet_frame_classifier_top.sv -----
// Top level of the Ethernet / IPv4 / UDP frame header classifier.
//
//  Channel   Dir   Payload                          Request accepted
//  rx        in    frame_byte[7:0], last_byte       valid && ready at clk rise
//  verdict   out   frame_class[2:0], payload_offset valid && ready at clk rise
//  cfg       in    cfg_wr_data[47:0] (own MAC)      cfg_wr_en at clk rise
//
// One byte is accepted every cycle while rx.ready is high; the edge that
// accepts the final byte of a frame pushes its result into the verdict buffer.
// The skid stage behind the result register holds one more result, so rx.ready
// drops only when two results are waiting on the verdict side.
// Reset (rst_n low, asynchronous) clears the frame state, the own MAC and
// both result stages.
module ethernet_frame_classifier_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [efc_pkg::MacWidth-1:0] cfg_wr_data,
    efc_byte_if.sink                     rx,
    efc_result_if.source                 verdict
);
    import efc_pkg::*;

    logic    accept;
    logic    push;
    result_t push_data;
    result_t out_data;

    assign accept = rx.valid && rx.ready;

    efc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .frame_byte  (rx.frame_byte),
        .last_byte   (rx.last_byte),
        .push        (push),
        .result      (push_data)
    );

    efc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .in_ready  (rx.ready),
        .out_valid (verdict.valid),
        .out_data  (out_data),
        .out_ready (verdict.ready)
    );

    assign verdict.frame_class    = out_data.frame_class;
    assign verdict.payload_offset = out_data.payload_offset;

endmodule

// ----- test/tb_ethernet_frame_classifier_top.sv -----
// Testbench for the Ethernet frame classifier: random frames checked against a frame-level model.
`timescale 1ns / 100ps

module tb_ethernet_frame_classifier_top;
    import efc_pkg::*;

    class verdict_scoreboard;
        logic [MacWidth-1:0]    own_mac;
        logic [CountWidth-1:0]  position;
        logic                   dest_ok;
        logic [15:0]            ether_type;
        logic [3:0]             ihl;
        logic [7:0]             protocol;
        logic [15:0]            src_port;
        logic [15:0]            dst_port;
        result_t                pending_verdicts[$];
        int unsigned            failures;

        function new();
            own_mac = '0;
            failures = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            position = '0;
            dest_ok = 1'b1;
            ether_type = '0;
            ihl = '0;
            protocol = '0;
            src_port = '0;
            dst_port = '0;
        endfunction

        function void set_own_mac(logic [MacWidth-1:0] mac);
            own_mac = mac;
        endfunction

        // Updates the header fields with one accepted byte; on the last byte the
        // expected verdict is queued.
        function void note_byte(logic [7:0] data, logic is_last);
            int unsigned pos;
            int unsigned base;
            logic [63:0] low_mask;
            frame_class_t cls;
            logic [OffsetWidth-1:0] off;

            pos = position;
            if (pos < MacBytes)
            begin
                if (data != own_mac[47 - 8*pos -: 8])
                    dest_ok = 1'b0;
            end
            if (pos == PosTypeHigh)
                ether_type[15:8] = data;
            if (pos == PosTypeLow)
                ether_type[7:0] = data;
            if (pos == EthHdrLen)
                ihl = data[3:0];
            if (pos == PosProtocol)
                protocol = data;

            // The port window follows the header length seen so far, even when
            // it overlaps the IPv4 header itself.
            base = EthHdrLen + 4 * ihl;
            if (pos >= base && pos < base + 4)
            begin
                case (pos - base)
                    0: src_port[15:8] = data;
                    1: src_port[7:0] = data;
                    2: dst_port[15:8] = data;
                    default: dst_port[7:0] = data;
                endcase
            end

            if (!is_last)
            begin
                if (pos < CountMax)
                    position = position + 1'b1;
                return;
            end

            // Destination bytes that never arrived compare as zero.
            if (pos < MacBytes - 1)
            begin
                low_mask = (64'd1 << (8 * (MacBytes - 1 - pos))) - 64'd1;
                if ((own_mac & low_mask) != 0)
                    dest_ok = 1'b0;
            end

            off = '0;
            if (ether_type == TypeIpv4)
            begin
                if (!dest_ok)
                begin
                    cls = CLASS_NOT_OURS;
                end
                else if (protocol == ProtoIcmp)
                begin
                    cls = CLASS_ICMP;
                    off = OffsetWidth'(base);
                end
                else if (protocol == ProtoUdp)
                begin
                    if (src_port == PortDhcpServer && dst_port == PortDhcpClient)
                    begin
                        cls = CLASS_DHCP_RESP;
                        off = OffsetWidth'(base + UdpHdrLen);
                    end
                    else
                    begin
                        cls = CLASS_UDP_OTHER;
                    end
                end
                else if (protocol == ProtoTcp)
                begin
                    cls = CLASS_TCP;
                    off = OffsetWidth'(base);
                end
                else
                begin
                    cls = CLASS_IPV4_OTHER;
                end
            end
            else if (ether_type == TypeArp)
            begin
                cls = CLASS_ARP;
                off = EthHdrLen;
            end
            else
            begin
                cls = CLASS_OTHER_TYPE;
            end

            pending_verdicts.push_back(result_t'{frame_class: cls, payload_offset: off});
            clear_frame();
        endfunction

        function void check_verdict(logic [2:0] cls, logic [OffsetWidth-1:0] off);
            result_t wanted;

            if (pending_verdicts.size() == 0)
            begin
                $error("verdict with no frame pending: frame_class %0d, payload_offset %0d",
                       cls, off);
                failures++;
                return;
            end
            wanted = pending_verdicts.pop_front();
            if (cls !== wanted.frame_class)
            begin
                $error("frame_class: expected %0d, actual %0d", wanted.frame_class, cls);
                failures++;
            end
            if (off !== wanted.payload_offset)
            begin
                $error("payload_offset: expected %0d, actual %0d", wanted.payload_offset, off);
                failures++;
            end
        endfunction
    endclass

    localparam int unsigned CycleLimit = 500000;
    localparam int unsigned HoldCycles = 300;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [MacWidth-1:0] cfg_wr_data = '0;

    efc_byte_if   rx_if();
    efc_result_if verdict_if();

    verdict_scoreboard sb = new();

    logic [7:0]  frame_bytes[$];
    int unsigned bytes_sent = 0;
    int unsigned cycle_count = 0;
    bit          hold_request = 1'b0;
    bit          holding = 1'b0;

    ethernet_frame_classifier_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rx          (rx_if),
        .verdict     (verdict_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        rx_if.valid = 1'b0;
        rx_if.frame_byte = '0;
        rx_if.last_byte = 1'b0;
        verdict_if.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (verdict_if.valid && verdict_if.ready)
                sb.check_verdict(verdict_if.frame_class, verdict_if.payload_offset);
            if (rx_if.valid && rx_if.ready)
                sb.note_byte(rx_if.frame_byte, rx_if.last_byte);
        end
    end

    // Mostly no idling, some short gaps and a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned roll;

        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Smallest ICMP frame whose header length field is zero, so the port
    // window lands on the byte carrying that field.
    function automatic void fill_icmp_ihl0(logic [MacWidth-1:0] station);
        frame_bytes.delete();
        for (int i = 0; i < 24; i++)
            frame_bytes.push_back(8'h00);
        for (int i = 0; i < 6; i++)
        begin
            frame_bytes[i] = station[47 - 8*i -: 8];
            frame_bytes[6 + i] = 8'hFF;
        end
        frame_bytes[PosTypeHigh] = TypeIpv4[15:8];
        frame_bytes[PosTypeLow] = TypeIpv4[7:0];
        frame_bytes[EthHdrLen] = 8'h40;
        frame_bytes[PosProtocol] = ProtoIcmp;
    endfunction

    function automatic void fill_random_frame(logic [MacWidth-1:0] station);
        int unsigned roll;
        int unsigned ihl_v;
        int unsigned base;
        int unsigned len;

        frame_bytes.delete();
        for (int i = 0; i < 200; i++)
            frame_bytes.push_back(8'($urandom()));

        if ($urandom_range(0, 99) < 15)
        begin
            // Plain noise.
            len = $urandom_range(1, 60);
        end
        else
        begin
            roll = $urandom_range(0, 99);
            for (int i = 0; i < 6; i++)
                frame_bytes[i] = (roll < 85) ? station[47 - 8*i -: 8] : 8'hFF;
            if (roll >= 75 && roll < 85)
                frame_bytes[$urandom_range(0, 5)] ^= 8'(1 << $urandom_range(0, 7));

            roll = $urandom_range(0, 99);
            if (roll < 65)
            begin
                frame_bytes[PosTypeHigh] = TypeIpv4[15:8];
                frame_bytes[PosTypeLow] = TypeIpv4[7:0];
            end
            else if (roll < 80)
            begin
                frame_bytes[PosTypeHigh] = TypeArp[15:8];
                frame_bytes[PosTypeLow] = TypeArp[7:0];
            end
            else if (roll < 90)
            begin
                frame_bytes[PosTypeHigh] = TypeIpv4[15:8];
            end

            ihl_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
            base = EthHdrLen + 4 * ihl_v;
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                frame_bytes[base] = PortDhcpServer[15:8];
                frame_bytes[base + 1] = PortDhcpServer[7:0];
            end
            if (roll < 50 || (roll >= 70 && roll < 80))
            begin
                frame_bytes[base + 2] = PortDhcpClient[15:8];
                frame_bytes[base + 3] = PortDhcpClient[7:0];
            end
            frame_bytes[EthHdrLen] = {($urandom_range(0, 1) != 0) ? 4'h4 : 4'($urandom()),
                                      4'(ihl_v)};

            roll = $urandom_range(0, 99);
            if (roll < 30)
                frame_bytes[PosProtocol] = ProtoUdp;
            else if (roll < 55)
                frame_bytes[PosProtocol] = ProtoIcmp;
            else if (roll < 75)
                frame_bytes[PosProtocol] = ProtoTcp;

            roll = $urandom_range(0, 99);
            if (roll < 8)
                len = $urandom_range(1, 30);
            else if (roll < 15)
                len = $urandom_range(126, 200);
            else
                len = ((base + 4 > 24) ? base + 4 : 24) + $urandom_range(0, 6);
        end

        while (frame_bytes.size() > len)
            void'(frame_bytes.pop_back());
    endfunction

    // Offers the bytes of frame_bytes one request at a time.
    task automatic send_frame();
        bit burst;
        int unsigned gap;

        burst = ($urandom_range(0, 3) == 0);
        foreach (frame_bytes[i])
        begin
            gap = (burst || holding) ? 0 : pick_gap();
            rx_if.valid <= 1'b1;
            rx_if.frame_byte <= frame_bytes[i];
            rx_if.last_byte <= (i == frame_bytes.size() - 1);
            @(posedge clk);
            while (!rx_if.ready)
                @(posedge clk);
            bytes_sent++;
            @(negedge clk);
            if (gap != 0)
            begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic write_own_mac(logic [MacWidth-1:0] mac);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mac;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_own_mac(mac);
    endtask

    task automatic drain_verdicts();
        while (sb.pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : verdict_sink
        int unsigned span;

        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                // Long hold-off so that both result stages fill and rx stalls.
                hold_request = 1'b0;
                holding = 1'b1;
                verdict_if.ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
                holding = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                verdict_if.ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
            else
            begin
                span = pick_gap();
                if (span != 0)
                begin
                    verdict_if.ready <= 1'b0;
                    repeat (span) @(negedge clk);
                end
                verdict_if.ready <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
        end
    end

    initial
    begin : stimulus
        logic [MacWidth-1:0] mac_plan[4];
        int unsigned phase_start;
        int unsigned phase_frames;

        mac_plan[0] = 48'h0211_2233_4455;
        mac_plan[1] = '0;
        mac_plan[2] = '1;
        mac_plan[3] = {16'($urandom()), 32'($urandom())};

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < 4; phase++)
        begin
            write_own_mac(mac_plan[phase]);
            if (phase == 0)
            begin
                frame_bytes = {8'h00};
                send_frame();
                fill_icmp_ihl0(mac_plan[0]);
                send_frame();
            end
            phase_start = bytes_sent;
            phase_frames = 0;
            while (bytes_sent - phase_start < 230 || phase_frames < 12)
            begin
                if (phase == 2 && phase_frames == 3)
                    hold_request = 1'b1;
                fill_random_frame(mac_plan[phase]);
                send_frame();
                phase_frames++;
            end
            rx_if.valid <= 1'b0;
            drain_verdicts();
        end

        repeat (10) @(negedge clk);
        if (sb.failures == 0 && sb.pending_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/efc_pkg.sv
rtl/efc_byte_if.sv
rtl/efc_result_if.sv
rtl/efc_parser.sv
rtl/efc_out_buf.sv
rtl/ethernet_frame_classifier_top.sv
test/tb_ethernet_frame_classifier_top.sv
